// ----- rtl/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the prefix-match route table
// Table geometry, status codes, the lookup token that walks the cell chain
// and the route entry that each cell stores.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int PORT_COUNT  = 16;

  // Field widths fixed by the item format.
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int PORT_W   = 4;
  localparam int TTL_W    = 8;
  localparam int STATUS_W = 3;

  // Counter and index widths derived from the table depth.
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Longest prefix a route can carry.
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  // Item kinds carried on the input tuser.
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_ROUTE = 1'b1
  } lpm_cmd_e;

  // Result codes carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_FORWARDED   = 3'd0,
    ST_TTL_EXPIRED = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_ADDED       = 3'd3,
    ST_FULL        = 3'd4
  } lpm_status_e;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
    logic              direct;
    logic [PORT_W-1:0] port;
  } lpm_entry_t;

  // Work item that travels down the chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic              valid;
    logic              is_route;
    logic              add_ok;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
    logic [CNT_W-1:0]  remain;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [PORT_W-1:0] best_port;
    logic [ADDR_W-1:0] best_hop;
  } lpm_token_t;

  // Mask of the high-order len bits; len runs from 0 to 32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

// ----- rtl/lpm_cell.sv -----
// ----------------------------------------------------------------------------
// lpm_cell: one route slot of the compare chain
// Holds one route and checks the passing token against it. A better match
// replaces the token's best route; the token moves on to the next cell.
// ----------------------------------------------------------------------------
module lpm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               wr_en_i,
  input  lpm_pkg::lpm_entry_t wr_entry_i,
  input  lpm_pkg::lpm_token_t tok_i,
  output lpm_pkg::lpm_token_t tok_o
);
  import lpm_pkg::*;

  lpm_entry_t entry_q;
  lpm_token_t tok_d;
  lpm_token_t tok_q;
  logic       live;
  logic       hit;
  logic       better;

  // Route storage, written once when its add command is accepted.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_entry_i;
    end
  end

  // The slot counts only while the token's route count has not run out here.
  assign live   = (tok_i.remain != '0);
  assign hit    = ((entry_q.prefix ^ tok_i.dest) & prefix_mask(entry_q.len)) == '0;
  assign better = tok_i.is_route && live && hit &&
                  (!tok_i.found || (entry_q.len > tok_i.best_len));

  // Update the best route seen so far.
  always_comb begin
    tok_d        = tok_i;
    tok_d.remain = live ? (tok_i.remain - CNT_W'(1)) : '0;
    if (better) begin
      tok_d.found     = 1'b1;
      tok_d.best_len  = entry_q.len;
      tok_d.best_port = entry_q.port;
      tok_d.best_hop  = entry_q.direct ? tok_i.dest : entry_q.hop;
    end
  end

  // Token register, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/longest_prefix_match_router_unit.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_router_unit: IPv4 longest-prefix-match route table
// Appends routes and looks up datagram headers through a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat is one command, chosen by s_axis_tuser_i: an add appends a
// route (prefix, length, optional next hop, port), a route command looks up a
// destination and TTL. Each command gives exactly one output beat, with the
// status on m_axis_tuser_o and port, next hop and decremented TTL on
// m_axis_tdata_o (zero unless the header is forwarded).
// A route is written into its cell in the cycle its add beat is accepted;
// lookups accepted earlier still see only the routes that existed then.
// A lookup token passes one cell per cycle through the TABLE_DEPTH (32) cells
// and then the output register. The whole chain moves together,
// so one beat is accepted every cycle while the output is taken.
// When the receiver stalls with a result waiting, the whole chain and the
// input side hold until that beat is taken.
// Reset empties the table and drops all beats in flight; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module longest_prefix_match_router_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Command input.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: prefix[32], pfx_len[6], has_next_hop[1],
  // next_hop_addr[32], port_in[4], dest_addr[32], ttl_in[8], zero pad[5]
  input  logic [119:0] s_axis_tdata_i,
  // tuser: command[1]
  input  logic         s_axis_tuser_i,
  // Result output.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: port_out[4], hop_out[32], ttl_out[8], zero pad[4]
  output logic [47:0]  m_axis_tdata_o,
  // tuser: status[3]
  output logic [2:0]   m_axis_tuser_o
);
  import lpm_pkg::*;

  // Unpacked input fields.
  logic [ADDR_W-1:0] in_prefix;
  logic [LEN_W-1:0]  in_plen;
  logic              in_has_hop;
  logic [ADDR_W-1:0] in_hop;
  logic [PORT_W-1:0] in_port;
  logic [ADDR_W-1:0] in_dest;
  logic [TTL_W-1:0]  in_ttl;
  logic              in_route;

  logic               advance;
  logic               accept;
  logic               add_ok;
  logic [CNT_W-1:0]   count_d;
  logic [CNT_W-1:0]   count_q;
  logic [TABLE_DEPTH-1:0] wr_en;
  lpm_entry_t         wr_entry;
  lpm_token_t         tok [TABLE_DEPTH+1];
  lpm_token_t         last_tok;

  logic               out_valid_d;
  logic               out_valid_q;
  lpm_status_e        status_d;
  lpm_status_e        status_q;
  logic [PORT_W-1:0]  port_d;
  logic [PORT_W-1:0]  port_q;
  logic [ADDR_W-1:0]  hop_d;
  logic [ADDR_W-1:0]  hop_q;
  logic [TTL_W-1:0]   ttl_d;
  logic [TTL_W-1:0]   ttl_q;

  assign in_prefix  = s_axis_tdata_i[31:0];
  assign in_plen    = s_axis_tdata_i[37:32];
  assign in_has_hop = s_axis_tdata_i[38];
  assign in_hop     = s_axis_tdata_i[70:39];
  assign in_port    = s_axis_tdata_i[74:71];
  assign in_dest    = s_axis_tdata_i[106:75];
  assign in_ttl     = s_axis_tdata_i[114:107];
  assign in_route   = (s_axis_tuser_i == CMD_ROUTE);

  // The chain moves whenever the output register is free or being emptied.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign accept          = s_axis_tvalid_i && advance;

  // An add succeeds while the table has room and the port exists.
  assign add_ok = (32'(count_q) < TABLE_DEPTH) && (32'(in_port) < PORT_COUNT);

  // Route entry built from the add command.
  always_comb begin
    wr_entry.prefix = in_prefix;
    wr_entry.len    = (in_plen > MAX_LEN) ? MAX_LEN : in_plen;
    wr_entry.hop    = in_has_hop ? in_hop : '0;
    wr_entry.direct = !in_has_hop;
    wr_entry.port   = in_port;
  end

  // Write strobe of the next free slot.
  always_comb begin
    wr_en = '0;
    if (accept && !in_route && add_ok) begin
      wr_en[count_q[IDX_W-1:0]] = 1'b1;
    end
  end

  // Route counter.
  assign count_d = (accept && !in_route && add_ok) ? (count_q + CNT_W'(1)) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Token entering the first cell.
  always_comb begin
    tok[0].valid     = s_axis_tvalid_i;
    tok[0].is_route  = in_route;
    tok[0].add_ok    = add_ok;
    tok[0].dest      = in_dest;
    tok[0].ttl       = in_ttl;
    tok[0].remain    = count_q;
    tok[0].found     = 1'b0;
    tok[0].best_len  = '0;
    tok[0].best_port = '0;
    tok[0].best_hop  = '0;
  end

  // The chain of route cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .wr_en_i    (wr_en[g]),
      .wr_entry_i (wr_entry),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  assign last_tok = tok[TABLE_DEPTH];

  // Final decision for the token leaving the chain.
  always_comb begin
    out_valid_d = last_tok.valid;
    port_d      = '0;
    hop_d       = '0;
    ttl_d       = '0;
    if (!last_tok.is_route) begin
      status_d = last_tok.add_ok ? ST_ADDED : ST_FULL;
    end else if (last_tok.ttl < TTL_W'(2)) begin
      status_d = ST_TTL_EXPIRED;
    end else if (!last_tok.found) begin
      status_d = ST_NO_ROUTE;
    end else begin
      status_d = ST_FORWARDED;
      port_d   = last_tok.best_port;
      hop_d    = last_tok.best_hop;
      ttl_d    = last_tok.ttl - TTL_W'(1);
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      port_q   <= port_d;
      hop_q    <= hop_d;
      ttl_q    <= ttl_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {4'd0, ttl_q, hop_q, port_q};

`ifndef SYNTHESIS
  // The route count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("route count above table depth");

  // A successful add grows the table by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_route && add_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("route count did not advance on add");

  // A waiting result blocks the input side.
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  // A forwarded header always leaves with a nonzero TTL.
  a_fwd_ttl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status_q == ST_FORWARDED)) |-> (ttl_q != '0))
    else $error("forwarded with zero ttl");

  // Results other than a forward carry zero fields.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status_q != ST_FORWARDED)) |->
      ((port_q == '0) && (hop_q == '0) && (ttl_q == '0)))
    else $error("nonzero fields on a non-forward result");
`endif

endmodule

// ----- verif/longest_prefix_match_router_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_prefix_match_router_unit_tb: self-checking bench for the route table
// A clocked driver sends add and route beats from a command queue. A shadow
// copy of the table works out the answer for every accepted beat, and a
// monitor compares each result beat with the oldest pending answer.
// ----------------------------------------------------------------------------
module longest_prefix_match_router_unit_tb;
  import lpm_pkg::*;

  localparam int RUN_LIMIT  = 200000;
  localparam int DRAIN_WAIT = 40;
  localparam int HOLD_LEN   = 400;

  // One command beat, field by field.
  typedef struct {
    lpm_cmd_e          cmd;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  plen;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
  } route_cmd_t;

  // One result beat, field by field.
  typedef struct {
    lpm_status_e       status;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] hop;
    logic [TTL_W-1:0]  ttl;
  } route_answer_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [119:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = CMD_ADD;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  longest_prefix_match_router_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Command beats waiting to be sent and answers waiting for their result beat.
  route_cmd_t    cmd_queue[$];
  route_answer_t pending_answers[$];

  // Shadow route table, updated in acceptance order.
  logic [ADDR_W-1:0] tbl_prefix[TABLE_DEPTH];
  logic [LEN_W-1:0]  tbl_len[TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_hop[TABLE_DEPTH];
  logic              tbl_direct[TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port[TABLE_DEPTH];
  int                tbl_count = 0;

  // Routes the stimulus has queued, used to aim lookups at stored prefixes.
  logic [ADDR_W-1:0] gen_prefix[$];
  logic [LEN_W-1:0]  gen_len[$];

  int send_idle_pct = 31;
  int recv_idle_pct = 80;
  int phase_no = 0;
  logic hold_rx = 1'b0;
  int answer_errors = 0;
  int cycle_cnt = 0;
  int status_seen[5] = '{default: 0};
  route_cmd_t cur_cmd;

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mask of the high-order len bits; lengths above 32 count as 32.
  function automatic logic [ADDR_W-1:0] high_bits_mask(input logic [LEN_W-1:0] len);
    int n;
    n = (len > ADDR_W) ? ADDR_W : int'(len);
    if (n == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - n);
  endfunction

  // Applies one command to the shadow table and returns the result it gives.
  function automatic route_answer_t route_table_answer(input route_cmd_t c);
    route_answer_t    r;
    int               best;
    logic [LEN_W-1:0] best_len;
    r.status = ST_NO_ROUTE;
    r.port   = '0;
    r.hop    = '0;
    r.ttl    = '0;
    best     = -1;
    best_len = '0;
    if (c.cmd == CMD_ADD) begin
      if (tbl_count >= TABLE_DEPTH || c.port >= PORT_COUNT) begin
        r.status = ST_FULL;
      end else begin
        tbl_prefix[tbl_count] = c.prefix;
        tbl_len[tbl_count]    = (c.plen > MAX_LEN) ? MAX_LEN : c.plen;
        tbl_hop[tbl_count]    = c.has_hop ? c.hop : '0;
        tbl_direct[tbl_count] = !c.has_hop;
        tbl_port[tbl_count]   = c.port;
        tbl_count++;
        r.status = ST_ADDED;
      end
    end else begin
      // Longest match wins; a strict compare keeps the earliest entry on a tie.
      for (int i = 0; i < tbl_count; i++) begin
        if (((tbl_prefix[i] ^ c.dest) & high_bits_mask(tbl_len[i])) == '0 &&
            (best < 0 || tbl_len[i] > best_len)) begin
          best     = i;
          best_len = tbl_len[i];
        end
      end
      if (c.ttl <= 1) begin
        r.status = ST_TTL_EXPIRED;
      end else if (best >= 0) begin
        r.status = ST_FORWARDED;
        r.port   = tbl_port[best];
        r.hop    = tbl_direct[best] ? c.dest : tbl_hop[best];
        r.ttl    = c.ttl - 1'b1;
      end
    end
    return r;
  endfunction

  task automatic queue_add(input logic [ADDR_W-1:0] prefix, input logic [LEN_W-1:0] plen,
                           input logic has_hop, input logic [ADDR_W-1:0] hop,
                           input logic [PORT_W-1:0] port);
    route_cmd_t c;
    c.cmd     = CMD_ADD;
    c.prefix  = prefix;
    c.plen    = plen;
    c.has_hop = has_hop;
    c.hop     = hop;
    c.port    = port;
    c.dest    = $urandom;
    c.ttl     = TTL_W'($urandom_range(0, 255));
    if (gen_prefix.size() < TABLE_DEPTH) begin
      gen_prefix = {gen_prefix, prefix};
      gen_len    = {gen_len, plen};
    end
    cmd_queue = {cmd_queue, c};
  endtask

  task automatic queue_route(input logic [ADDR_W-1:0] dest, input logic [TTL_W-1:0] ttl);
    route_cmd_t c;
    c.cmd     = CMD_ROUTE;
    c.prefix  = $urandom;
    c.plen    = LEN_W'($urandom_range(0, 63));
    c.has_hop = 1'($urandom_range(0, 1));
    c.hop     = $urandom;
    c.port    = PORT_W'($urandom_range(0, 15));
    c.dest    = dest;
    c.ttl     = ttl;
    cmd_queue = {cmd_queue, c};
  endtask

  // Random mix: lookups with some adds, more adds until the table fills; lookups
  // mostly aim at stored prefixes, some are near misses, and later adds find it full.
  task automatic queue_random(input int n);
    int                k;
    int                pick;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] addr;
    logic [TTL_W-1:0]  ttl;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < ((gen_prefix.size() < TABLE_DEPTH) ? 30 : 5)) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) len = '0;
        else if (pick < 10) len = LEN_W'($urandom_range(33, 63));
        else len = LEN_W'($urandom_range(1, 32));
        addr = $urandom;
        if (gen_prefix.size() != 0 && $urandom_range(0, 1)) begin
          // Nest the new route inside or around an existing one.
          k    = $urandom_range(0, gen_prefix.size() - 1);
          m    = high_bits_mask(gen_len[k]);
          addr = (gen_prefix[k] & m) | (addr & ~m);
        end
        queue_add(addr, len, 1'($urandom_range(0, 1)), $urandom,
                  PORT_W'($urandom_range(0, 15)));
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: ttl = 8'd0;
          1: ttl = 8'd1;
          2: ttl = 8'd2;
          3: ttl = 8'd255;
          default: ttl = TTL_W'($urandom_range(3, 254));
        endcase
        addr = $urandom;
        if (gen_prefix.size() != 0 && $urandom_range(0, 99) < 80) begin
          k    = $urandom_range(0, gen_prefix.size() - 1);
          len  = (gen_len[k] > MAX_LEN) ? MAX_LEN : gen_len[k];
          m    = high_bits_mask(len);
          addr = (gen_prefix[k] & m) | (addr & ~m);
          // Near miss: flip the lowest bit the prefix covers.
          if (len != 0 && $urandom_range(0, 9) == 0) addr[ADDR_W - len] = ~addr[ADDR_W - len];
        end
        queue_route(addr, ttl);
      end
    end
  endtask

  // Sender: offers the next queued beat, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= CMD_ADD;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_answers = {pending_answers, route_table_answer(cur_cmd)};
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          s_axis_tdata_i  <= {5'b0, cur_cmd.ttl, cur_cmd.dest, cur_cmd.port, cur_cmd.hop,
                              cur_cmd.has_hop, cur_cmd.plen, cur_cmd.prefix};
          s_axis_tuser_i  <= cur_cmd.cmd;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random, or for the whole hold-off stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Flags one bad result beat; only the first few are printed.
  task automatic flag_result(input string what, input route_answer_t want);
    answer_errors++;
    if (answer_errors <= 10) begin
      $display("%s: expected status %0d port %0d hop %08h ttl %0d,", what,
               want.status, want.port, want.hop, want.ttl);
      $display("  got status %0d port %0d hop %08h ttl %0d", m_axis_tuser_o,
               m_axis_tdata_o[3:0], m_axis_tdata_o[35:4], m_axis_tdata_o[43:36]);
    end
  endtask

  // Monitor: checks each result beat against the oldest pending answer.
  always @(posedge clk_i) begin
    route_answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_answers.size() == 0) begin
        want.status = ST_FORWARDED;
        want.port   = '0;
        want.hop    = '0;
        want.ttl    = '0;
        flag_result("result beat with nothing pending", want);
      end else begin
        want = pending_answers.pop_front();
        status_seen[want.status]++;
        if (m_axis_tuser_o !== want.status || m_axis_tdata_o[3:0] !== want.port ||
            m_axis_tdata_o[35:4] !== want.hop || m_axis_tdata_o[43:36] !== want.ttl) begin
          flag_result("result mismatch", want);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending", cycle_cnt,
               pending_answers.size());
      $display("longest_prefix_match_router_unit_tb: done, errors");
      $finish;
    end
  end

  // Long receiver hold-off early in the last phase, with the sender busy.
  initial begin
    while (phase_no != 3) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Stimulus and phases.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    phase_no = 1;

    // Lookups into an empty table.
    queue_route(32'hC0A80001, 8'd64);
    queue_route(32'h0A000001, 8'd0);
    queue_route(32'h0A000001, 8'd1);
    // Nested routes, a tie, an over-long length and the address extremes.
    queue_add(32'h0A000000, 6'd8, 1'b1, 32'hC0A80101, 4'd3);
    queue_add(32'h0A010000, 6'd16, 1'b0, 32'h12345678, 4'd5);
    queue_add(32'h0A010203, 6'd32, 1'b1, 32'hFFFFFFFF, 4'd15);
    queue_add(32'h0A010000, 6'd16, 1'b1, 32'h0A0A0A0A, 4'd7);
    queue_add(32'hAC100000, 6'd63, 1'b1, 32'h01020304, 4'd0);
    queue_add(32'hFFFFFFFF, 6'd32, 1'b0, 32'h0, 4'd9);
    queue_add(32'h00000000, 6'd1, 1'b1, 32'h0, 4'd1);
    queue_route(32'h0AC80101, 8'd255);
    queue_route(32'h0A010909, 8'd2);
    queue_route(32'h0A010203, 8'd100);
    queue_route(32'h0A010203, 8'd1);
    queue_route(32'hAC100000, 8'd50);
    queue_route(32'hAC100001, 8'd50);
    queue_route(32'hFFFFFFFF, 8'd255);
    queue_route(32'h7FFFFFFF, 8'd3);
    queue_route(32'hC0000000, 8'd9);
    // Default route, then lookups that fall back to it or beat it.
    queue_add(32'h12345678, 6'd0, 1'b0, 32'h0, 4'd2);
    queue_route(32'hC0000000, 8'd9);
    queue_route(32'h0A010203, 8'd0);
    queue_route(32'h00000000, 8'd255);
    queue_random(560);

    // Each phase ends with the sender paused until every answer is in.
    for (int p = 2; p <= 3; p++) begin
      while (cmd_queue.size() != 0 || s_axis_tvalid_i || pending_answers.size() != 0)
        @(negedge clk_i);
      send_idle_pct <= (p == 2) ? 80 : 0;
      recv_idle_pct <= (p == 2) ? 31 : 0;
      @(negedge clk_i);
      phase_no = p;
      queue_random(585);
    end

    while (cmd_queue.size() != 0 || s_axis_tvalid_i || pending_answers.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d forwarded, %0d ttl expired, %0d no route, %0d added, %0d table full",
             status_seen[ST_FORWARDED], status_seen[ST_TTL_EXPIRED], status_seen[ST_NO_ROUTE],
             status_seen[ST_ADDED], status_seen[ST_FULL]);
    $display("three idle mixes and a %0d-cycle receiver hold-off, %0d bad beats",
             HOLD_LEN, answer_errors);
    if (answer_errors == 0 && pending_answers.size() == 0) begin
      $display("longest_prefix_match_router_unit_tb: done, clean");
    end else begin
      $display("longest_prefix_match_router_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
